[rtl/assert_macros.svh]
// assertion macros shared by the dense member set rtl
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every clock edge outside reset
`define DMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define DMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DMS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/dms_pkg.sv]
// types and constants of the dense member set
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int ID_W       = 10;
  localparam int CNT_W      = 11;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [ID_W-1:0]  member_id;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] member_count;
    logic             was_listed;
  } out_item_t;

  // port requests from the sequencer to the two memories
  typedef struct packed {
    logic              list_we;
    logic [ADDR_W-1:0] list_waddr;
    logic [ID_W-1:0]   list_wdata;
    logic [ADDR_W-1:0] list_raddr;
    logic              flag_we;
    logic [ADDR_W-1:0] flag_waddr;
    logic              flag_wdata;
    logic [ADDR_W-1:0] flag_raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[rtl/dense_member_set.sv]
// dense member set, top level: flag memory, list memory, sequencer, result register
// depends on dms_pkg, dms_ram, dms_ctrl and assert_macros.svh
//
// keeps a set of slot ids twice: a presence flag per id and a dense list with a count.
// one item at a time. a remove of a listed id scans the list memory linearly from
// its first entry until it finds the id, one entry per cycle through its single read
// port. add needs no scan since the flag memory tells whether the id is already listed.
// after reset a clearing pass zeroes the 1024 flags, one per cycle, and in_stall stays
// high until the pass is done. the result sits in an output register, so a new item
// is taken while an earlier result still waits on out_stall.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dense_member_set (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dms_pkg::in_item_t  in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dms_pkg::out_item_t      out_data
);

  logic                        ctrl_idle;
  logic                        out_free;
  logic                        res_load;
  dms_pkg::out_item_t          res;
  dms_pkg::mem_req_t           mem_req;
  logic [dms_pkg::ID_W-1:0]    list_rdata;
  logic                        flag_rdata;

  logic                        out_valid_r, out_valid_nxt;
  dms_pkg::out_item_t          out_data_r, out_data_nxt;

  // new transfer only when the sequencer waits for work
  assign in_stall = !ctrl_idle;

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  // dense list of member ids, entries at or above the count are never used
  dms_ram #(
    .WIDTH (dms_pkg::ID_W),
    .DEPTH (dms_pkg::SLOT_COUNT)
  ) u_list_ram (
    .clk   (clk),
    .we    (mem_req.list_we),
    .waddr (mem_req.list_waddr),
    .wdata (mem_req.list_wdata),
    .raddr (mem_req.list_raddr),
    .rdata (list_rdata)
  );

  // presence flags, zeroed by the clearing pass after reset
  dms_ram #(
    .WIDTH (1),
    .DEPTH (dms_pkg::SLOT_COUNT)
  ) u_flag_ram (
    .clk   (clk),
    .we    (mem_req.flag_we),
    .waddr (mem_req.flag_waddr),
    .wdata (mem_req.flag_wdata),
    .raddr (mem_req.flag_raddr),
    .rdata (flag_rdata)
  );

  dms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .idle       (ctrl_idle),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .mem_req    (mem_req),
    .list_rdata (list_rdata),
    .flag_rdata (flag_rdata)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one item in flight: a transfer closes the input until its result is loaded into the output register
  `DMS_ASSERT(a_one_in_flight, clk, rst_n, (in_valid && !in_stall) |=> in_stall, "second transfer while an item is in flight")
  // a stalled result stays offered
  `DMS_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "stalled result dropped")
  // a stalled result keeps its fields
  `DMS_ASSERT(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> $stable(out_data), "stalled result changed")

endmodule

`default_nettype wire

[rtl/dms_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/dms_ctrl.sv]
// sequencer of the dense member set: flag lookup, list scan, swap remove
// depends on dms_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dms_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire dms_pkg::in_item_t          in_data,
  output logic                            idle,
  input  wire logic                       out_free,
  output logic                            res_load,
  output dms_pkg::out_item_t              res,
  output dms_pkg::mem_req_t               mem_req,
  input  wire logic [dms_pkg::ID_W-1:0]   list_rdata,
  input  wire logic                       flag_rdata
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FLAG  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_MOVE  = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [dms_pkg::ADDR_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [dms_pkg::CNT_W-1:0]      len_r, len_nxt;
  dms_pkg::op_t                   op_r, op_nxt;
  logic [dms_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [dms_pkg::CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                           cmp_v_r, cmp_v_nxt;
  logic [dms_pkg::ADDR_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic [dms_pkg::ADDR_W-1:0]     pos_r, pos_nxt;
  logic                           listed_r, listed_nxt;
  logic                           hit;
  logic                           issue;
  logic [dms_pkg::CNT_W-1:0]      len_m1;
  logic [dms_pkg::CNT_W-1:0]      len_p1;

  assign hit    = cmp_v_r && (list_rdata == id_r);
  assign issue  = rd_idx_r < len_r;
  assign len_m1 = len_r - dms_pkg::CNT_W'(1);
  assign len_p1 = len_r + dms_pkg::CNT_W'(1);
  assign idle   = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    len_nxt     = len_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    pos_nxt     = pos_r;
    listed_nxt  = listed_r;
    res_load    = 1'b0;
    res.member_count = len_r;
    res.was_listed   = listed_r;

    mem_req            = '0;
    mem_req.flag_raddr = in_data.member_id;
    mem_req.list_raddr = rd_idx_r[dms_pkg::ADDR_W-1:0];

    case (state_r)
      ST_CLEAR: begin
        mem_req.flag_we    = 1'b1;
        mem_req.flag_waddr = clr_idx_r;
        mem_req.flag_wdata = 1'b0;
        clr_idx_nxt        = clr_idx_r + dms_pkg::ADDR_W'(1);
        if (clr_idx_r == dms_pkg::ADDR_W'(dms_pkg::SLOT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          id_nxt    = in_data.member_id;
          state_nxt = ST_FLAG;
        end
      end
      ST_FLAG: begin
        mem_req.flag_we    = 1'b1;
        mem_req.flag_waddr = id_r;
        if (op_r == dms_pkg::OP_ADD) begin
          mem_req.flag_wdata = 1'b1;
          listed_nxt         = flag_rdata;
          // flag clear means not listed: append without a scan
          if (!flag_rdata && (len_r < dms_pkg::CNT_W'(dms_pkg::SLOT_COUNT))) begin
            mem_req.list_we    = 1'b1;
            mem_req.list_waddr = len_r[dms_pkg::ADDR_W-1:0];
            mem_req.list_wdata = id_r;
            len_nxt            = len_p1;
          end
          state_nxt = ST_RESP;
        end else begin
          mem_req.flag_wdata = 1'b0;
          if (flag_rdata) begin
            rd_idx_nxt = '0;
            cmp_v_nxt  = 1'b0;
            state_nxt  = ST_SCAN;
          end else begin
            listed_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // fetch the tail entry to move into the hole
          pos_nxt            = cmp_idx_r;
          mem_req.list_raddr = len_m1[dms_pkg::ADDR_W-1:0];
          cmp_v_nxt          = 1'b0;
          state_nxt          = ST_MOVE;
        end else if (issue) begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = rd_idx_r[dms_pkg::ADDR_W-1:0];
          rd_idx_nxt  = rd_idx_r + dms_pkg::CNT_W'(1);
        end else begin
          cmp_v_nxt = 1'b0;
          if (!cmp_v_r) begin
            listed_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end
        end
      end
      ST_MOVE: begin
        mem_req.list_we    = 1'b1;
        mem_req.list_waddr = pos_r;
        mem_req.list_wdata = list_rdata;
        len_nxt            = len_m1;
        listed_nxt         = 1'b1;
        state_nxt          = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      len_r     <= '0;
      cmp_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      len_r     <= len_nxt;
      cmp_v_r   <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pos_r     <= pos_nxt;
    listed_r  <= listed_nxt;
  end

  `DMS_ASSERT(a_len_bound, clk, rst_n, len_r <= dms_pkg::CNT_W'(dms_pkg::SLOT_COUNT), "list length beyond slot count")
  `DMS_ASSERT(a_move_nonempty, clk, rst_n, (state_r == ST_MOVE) |-> (len_r != '0), "swap remove on an empty list")
  `DMS_ASSERT(a_idle_no_write, clk, rst_n, (state_r == ST_IDLE) |-> !(mem_req.flag_we || mem_req.list_we), "memory write while idle")

endmodule

`default_nettype wire

[tb/sv/tb_dense_member_set.sv]
// self-checking testbench for dense_member_set: directed and random add/remove traffic
// depends on dms_pkg and the dense_member_set rtl; keeps its own shadow of flags and list
`timescale 1ns / 1ps

module tb_dense_member_set;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  dms_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall;
  dms_pkg::out_item_t out_data;

  dense_member_set u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns period
  initial begin
    forever #2 clk = ~clk;
  end

  // shadow of the block: presence flags, dense roster and its length
  bit                       flag_mem [dms_pkg::SLOT_COUNT];
  logic [dms_pkg::ID_W-1:0] roster   [dms_pkg::SLOT_COUNT];
  int unsigned              roster_len = 0;

  dms_pkg::in_item_t  op_backlog [$];   // items not yet offered
  dms_pkg::out_item_t tally_due  [$];   // expected count/listed pairs, oldest first

  int items_sent     = 0;
  int results_seen   = 0;
  int total_items    = 0;
  int mismatch_count = 0;
  int in_gap         = 0;
  int out_hold       = 0;
  int press_left     = 0;
  bit pressure_done  = 1'b0;
  bit rand_stall     = 1'b0;
  bit press_hold     = 1'b0;

  assign out_stall = rand_stall || press_hold;

  // applies one add/remove to the shadow and returns the result it should produce;
  // ids are 10 bits wide so an id beyond the slot count cannot occur
  function automatic dms_pkg::out_item_t apply_member_op(dms_pkg::in_item_t item);
    int unsigned        pos;
    bit                 listed;
    dms_pkg::out_item_t res;
    pos = roster_len;
    for (int unsigned k = 0; k < roster_len; k++) begin
      if (roster[k] == item.member_id) begin
        pos = k;
        break;
      end
    end
    listed = (pos < roster_len);
    if (item.operation == dms_pkg::OP_ADD) begin
      flag_mem[item.member_id] = 1'b1;
      // a full roster keeps its count, the flag is still set
      if (!listed && roster_len < dms_pkg::SLOT_COUNT) begin
        roster[roster_len] = item.member_id;
        roster_len++;
      end
    end else begin
      flag_mem[item.member_id] = 1'b0;
      // swap-remove: the last entry fills the hole
      if (listed) begin
        roster[pos] = roster[roster_len - 1];
        roster_len--;
      end
    end
    res.member_count = dms_pkg::CNT_W'(roster_len);
    res.was_listed   = listed;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("mismatch at result %0d: %s got %0d, want %0d", results_seen, what, got, want);
    end
  endtask

  task automatic queue_op(dms_pkg::op_t op, int id);
    dms_pkg::in_item_t item;
    item.operation = op;
    item.member_id = dms_pkg::ID_W'(id);
    op_backlog.push_back(item);
  endtask

  // sender: a transfer happens when valid is high and stall low; a stalled item holds
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tally_due.push_back(apply_member_op(in_data));
        items_sent++;
      end
      // free to change the offer only when nothing is stalled
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() > 60 && $urandom_range(0, 9) == 0) begin
          // start an idle burst; in_gap holds the further idle slots after this one
          in_gap = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= op_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer against the oldest expectation, stalls in bursts
  always @(posedge clk) begin
    dms_pkg::out_item_t want;
    if (!rst_n) begin
      rand_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tally_due.size() == 0) begin
          report_mismatch("result with nothing pending, count", out_data.member_count, -1);
        end else begin
          want = tally_due.pop_front();
          if (out_data.member_count !== want.member_count)
            report_mismatch("member_count", out_data.member_count, want.member_count);
          if (out_data.was_listed !== want.was_listed)
            report_mismatch("was_listed", out_data.was_listed, want.was_listed);
        end
        results_seen++;
      end
      if (out_hold > 0) begin
        out_hold--;
        rand_stall <= 1'b1;
      end else if (results_seen < total_items - 60 && $urandom_range(0, 9) == 0) begin
        out_hold = $urandom_range(0, 8);
        rand_stall <= 1'b1;
      end else begin
        rand_stall <= 1'b0;
      end
    end
  end

  // long hold-off: output register fills and the block stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      press_hold <= 1'b0;
    end else if (!pressure_done && results_seen >= 300) begin
      pressure_done = 1'b1;
      press_left    = 80;
      press_hold <= 1'b1;
    end else if (press_left > 1) begin
      press_left--;
      press_hold <= 1'b1;
    end else begin
      press_left = 0;
      press_hold <= 1'b0;
    end
  end

  initial begin : main_seq
    int id_pool [$];
    int add_pct;
    int pick;
    int id;

    // directed: id extremes, alternating bit patterns, add of a listed id,
    // remove of an unlisted id, remove of first/last entry, drain to empty
    queue_op(dms_pkg::OP_REMOVE, 5);
    queue_op(dms_pkg::OP_ADD,    0);
    queue_op(dms_pkg::OP_ADD,    1023);
    queue_op(dms_pkg::OP_ADD,    0);
    queue_op(dms_pkg::OP_ADD,    341);
    queue_op(dms_pkg::OP_ADD,    682);
    queue_op(dms_pkg::OP_ADD,    512);
    queue_op(dms_pkg::OP_ADD,    682);
    queue_op(dms_pkg::OP_REMOVE, 77);
    queue_op(dms_pkg::OP_REMOVE, 512);
    queue_op(dms_pkg::OP_REMOVE, 0);
    queue_op(dms_pkg::OP_REMOVE, 0);
    queue_op(dms_pkg::OP_ADD,    1);
    queue_op(dms_pkg::OP_ADD,    1022);
    queue_op(dms_pkg::OP_REMOVE, 1023);
    queue_op(dms_pkg::OP_REMOVE, 682);
    queue_op(dms_pkg::OP_REMOVE, 341);
    queue_op(dms_pkg::OP_REMOVE, 1);
    queue_op(dms_pkg::OP_REMOVE, 1022);
    queue_op(dms_pkg::OP_REMOVE, 1022);

    // random: growth, then churn, then drain
    for (int n = 0; n < 560; n++) begin
      add_pct = (n < 200) ? 85 : (n < 440) ? 50 : 15;
      if ($urandom_range(0, 99) < add_pct) begin
        if (id_pool.size() > 0 && $urandom_range(0, 99) < 20)
          id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else
          id = $urandom_range(0, dms_pkg::SLOT_COUNT - 1);
        id_pool.push_back(id);
        queue_op(dms_pkg::OP_ADD, id);
      end else begin
        if (id_pool.size() > 0 && $urandom_range(0, 99) < 85) begin
          pick = $urandom_range(0, id_pool.size() - 1);
          id = id_pool[pick];
          id_pool.delete(pick);
        end else begin
          id = $urandom_range(0, dms_pkg::SLOT_COUNT - 1);
        end
        queue_op(dms_pkg::OP_REMOVE, id);
      end
    end
    total_items = op_backlog.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (items_sent == total_items);
    wait (tally_due.size() == 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_dense_member_set passed");
    end else begin
      $display("tb_dense_member_set failed");
    end
    $finish;
  end

  // watchdog, far beyond the clearing pass plus worst-case scans for every item
  initial begin
    #10_000_000;
    $display("tb_dense_member_set failed");
    $finish;
  end

endmodule

[dense_member_set.f]
+incdir+rtl
rtl/dms_pkg.sv
rtl/dms_ram.sv
rtl/dms_ctrl.sv
rtl/dense_member_set.sv
tb/sv/tb_dense_member_set.sv
